>>> sv/rcw_pkg.sv
// Shared types, constants and helpers for the rainbow color wheel.
package rcw_pkg;

  // Fixed field widths
  localparam int unsigned PosW  = 8;   // LED position
  localparam int unsigned CntW  = 9;   // LED count register
  localparam int unsigned ChanW = 8;   // channel level / peak register
  localparam int unsigned ProdW = PosW + ChanW;
  localparam int unsigned BndW  = 12;  // count times section index, plus rounding
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = CntW;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_NUM_LEDS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PEAK     = 1'b1;

  // Reset values
  localparam logic [CntW-1:0]  NumLedsRst = 9'd1;
  localparam logic [ChanW-1:0] PeakRst    = 8'd255;

  // Reciprocal of six for x / 6 with x below 2^17
  localparam int unsigned Sections = 6;
  localparam logic [15:0] Recip6   = 16'd43691;
  localparam int unsigned Recip6Sh = 18;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sec_e;

  // Section start points: lo = floor(n*k/6), hi = ceil(n*k/6)
  typedef struct packed {
    logic [Sections:0][CntW-1:0]   lo;
    logic [Sections-1:1][CntW-1:0] hi;
  } bounds_t;

  // Beat carried through the divider stages
  typedef struct packed {
    sec_e             sec;
    logic             oor;
    logic             zero;
    logic [ProdW-1:0] rem;
    logic [CntW-1:0]  dvs;
    logic [ChanW-1:0] quo;
  } div_t;

  // floor(x / 6) by reciprocal multiply
  function automatic logic [CntW-1:0] div6(input logic [BndW-1:0] x);
    logic [BndW+15:0] p;
    p = (BndW + 16)'(x) * (BndW + 16)'(Recip6);
    return p[Recip6Sh +: CntW];
  endfunction

endpackage

>>> sv/rcw_bounds.sv
// Section boundary table, recomputed from the LED count every cycle.
module rcw_bounds (
  input  logic                     clk_i,
  input  logic [rcw_pkg::CntW-1:0] n_i,
  output rcw_pkg::bounds_t         bounds_o
);
  import rcw_pkg::*;

  bounds_t bounds_d, bounds_q;

  // floor and ceil of n*k/6 for each section edge
  always_comb begin
    logic [BndW-1:0] x;
    bounds_d = '0;
    for (int k = 0; k <= Sections; k++) begin
      x = BndW'(n_i) * BndW'(k);
      bounds_d.lo[k] = div6(x);
      if (k >= 1 && k < Sections) begin
        bounds_d.hi[k] = div6(x + BndW'(Sections - 1));
      end
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    bounds_q <= bounds_d;
  end

  assign bounds_o = bounds_q;

endmodule

>>> sv/rcw_locate.sv
// Front stages: range check, section search, offset/size, ramp numerator.
module rcw_locate (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [rcw_pkg::PosW-1:0]  pos_i,
  input  logic [rcw_pkg::CntW-1:0]  n_i,
  input  rcw_pkg::bounds_t          bounds_i,
  input  logic [rcw_pkg::ChanW-1:0] peak_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output rcw_pkg::div_t             data_o
);
  import rcw_pkg::*;

  // Stage A: position and range flag
  logic            a_valid_q, a_ready;
  logic [PosW-1:0] a_pos_q;
  logic            a_oor_q;
  // Stage B: section index
  logic            b_valid_q, b_ready;
  logic [PosW-1:0] b_pos_q;
  logic            b_oor_q;
  sec_e            b_sec_d, b_sec_q;
  // Stage C: offset into and size of the section
  logic            c_valid_q, c_ready;
  logic            c_oor_q;
  sec_e            c_sec_q;
  logic [PosW-1:0] c_offs_d, c_offs_q;
  logic [CntW-1:0] c_size_d, c_size_q;
  // Stage D: numerator offs*peak
  logic            d_valid_q;
  logic            d_ready_w;
  div_t            d_data_d, d_data_q;

  // Ready chain; a stage takes a beat when empty or when it drains
  assign d_ready_w = !d_valid_q || ready_i;
  assign c_ready = !c_valid_q || d_ready_w;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // Section search: count ceil boundaries at or below the position
  always_comb begin
    logic [2:0] cnt;
    cnt = '0;
    for (int k = 1; k < Sections; k++) begin
      cnt = cnt + 3'(CntW'(a_pos_q) >= bounds_i.hi[k]);
    end
    b_sec_d = sec_e'(cnt);
  end

  // Section start, next start, offset and size
  always_comb begin
    logic [CntW-1:0] start, next;
    start    = bounds_i.lo[3'(b_sec_q)];
    next     = bounds_i.lo[3'(b_sec_q) + 3'd1];
    c_size_d = next - start;
    c_offs_d = PosW'(CntW'(b_pos_q) - start);
  end

  // Numerator for the ramp division
  always_comb begin
    d_data_d      = '0;
    d_data_d.sec  = c_sec_q;
    d_data_d.oor  = c_oor_q;
    d_data_d.zero = (c_size_q == '0);
    d_data_d.rem  = ProdW'(c_offs_q) * ProdW'(peak_i);
    d_data_d.dvs  = c_size_q;
    d_data_d.quo  = '0;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (a_ready)   a_valid_q <= valid_i;
      if (b_ready)   b_valid_q <= a_valid_q;
      if (c_ready)   c_valid_q <= b_valid_q;
      if (d_ready_w) d_valid_q <= c_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_pos_q <= pos_i;
      a_oor_q <= CntW'(pos_i) >= n_i;
    end
    if (b_ready && a_valid_q) begin
      b_pos_q <= a_pos_q;
      b_oor_q <= a_oor_q;
      b_sec_q <= b_sec_d;
    end
    if (c_ready && b_valid_q) begin
      c_oor_q  <= b_oor_q;
      c_sec_q  <= b_sec_q;
      c_offs_q <= c_offs_d;
      c_size_q <= c_size_d;
    end
    if (d_ready_w && c_valid_q) begin
      d_data_q <= d_data_d;
    end
  end

  assign valid_o = d_valid_q;
  assign data_o  = d_data_q;

  // In range, the offset never passes the section size
  a_offs_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && !c_oor_q |-> CntW'(c_offs_q) <= c_size_q)
    else $error("section offset exceeds section size");

endmodule

>>> sv/rcw_div_stage.sv
// One restoring-division step: decides quotient bit BIT of rem / dvs.
module rcw_div_stage #(
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  rcw_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rcw_pkg::div_t data_o
);
  import rcw_pkg::*;

  localparam int unsigned TrialW = ProdW + CntW;

  logic valid_q;
  div_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // Trial subtract of the shifted divisor
  always_comb begin
    logic [TrialW-1:0] trial;
    trial  = TrialW'(data_i.dvs) << BIT;
    data_d = data_i;
    if (TrialW'(data_i.rem) >= trial) begin
      data_d.rem      = data_i.rem - trial[ProdW-1:0];
      data_d.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/rcw_shade.sv
// Output stage: maps section and ramp onto red, green and blue.
module rcw_shade (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  rcw_pkg::div_t             data_i,
  input  logic [rcw_pkg::ChanW-1:0] peak_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [rcw_pkg::ChanW-1:0] red_o,
  output logic [rcw_pkg::ChanW-1:0] green_o,
  output logic [rcw_pkg::ChanW-1:0] blue_o,
  output logic                      oor_o
);
  import rcw_pkg::*;

  logic             valid_q;
  logic [ChanW-1:0] red_d, green_d, blue_d;
  logic [ChanW-1:0] red_q, green_q, blue_q;
  logic             oor_q;

  assign ready_o = !valid_q || ready_i;

  // Channel selection per section
  always_comb begin
    logic [ChanW-1:0] ramp, down;
    ramp    = data_i.zero ? '0 : data_i.quo;
    down    = peak_i - ramp;
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    if (!data_i.oor) begin
      case (data_i.sec)
        SEC_RED_YELLOW:   begin red_d   = peak_i; green_d = ramp; end
        SEC_YELLOW_GREEN: begin green_d = peak_i; red_d   = down; end
        SEC_GREEN_CYAN:   begin green_d = peak_i; blue_d  = ramp; end
        SEC_CYAN_BLUE:    begin blue_d  = peak_i; green_d = down; end
        SEC_BLUE_MAGENTA: begin blue_d  = peak_i; red_d   = ramp; end
        default:          begin red_d   = peak_i; blue_d  = down; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      oor_q   <= data_i.oor;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign oor_o   = oor_q;

  // Division finished: remainder below divisor, quotient within peak
  a_rem_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !data_i.oor && !data_i.zero |-> data_i.rem < ProdW'(data_i.dvs))
    else $error("ramp division left a remainder at or above the divisor");

  a_quo_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !data_i.oor && !data_i.zero |-> data_i.quo <= peak_i)
    else $error("ramp above peak brightness");

endmodule

>>> sv/rainbow_color_wheel.sv
// Rainbow color wheel: one beat per cycle while the output is not stalled; four front
// stages (range check, section search, offset and size, ramp numerator), one
// restoring-division stage per ramp bit, and an output register. The divider stages
// decide one quotient bit each; every stage holds a valid bit and takes a new beat
// whenever it is empty or draining, so bubbles close up and input is still taken
// while a finished result waits, until every stage is full. The section table is
// registered from the saturated LED count register.
module rainbow_color_wheel #(
  parameter int unsigned MAX_LEDS     = 256,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rcw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcw_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rcw_pkg::PosW-1:0]     position_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rcw_pkg::ChanW-1:0]    red_o,
  output logic [rcw_pkg::ChanW-1:0]    green_o,
  output logic [rcw_pkg::ChanW-1:0]    blue_o,
  output logic                         out_of_range_o
);
  import rcw_pkg::*;

  // Largest count the 9-bit register can hold, capped by MAX_LEDS
  localparam int unsigned CntMax = (1 << CntW) - 1;
  localparam int unsigned NMax   = (MAX_LEDS < CntMax) ? MAX_LEDS : CntMax;
  // Ramp bits actually used
  localparam int unsigned PW     = (CHANNEL_BITS < ChanW) ? CHANNEL_BITS : ChanW;

  logic [CntW-1:0]  num_leds_q;
  logic [ChanW-1:0] peak_q;
  logic [CntW-1:0]  n_sat;
  logic [ChanW-1:0] peak_m;
  bounds_t          bounds;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_leds_q <= NumLedsRst;
      peak_q     <= PeakRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUM_LEDS: num_leds_q <= cfg_wdata_i;
        CFG_PEAK:     peak_q     <= cfg_wdata_i[ChanW-1:0];
        default:      ;
      endcase
    end
  end

  // Count saturation and peak mask
  assign n_sat = (num_leds_q > CntW'(NMax)) ? CntW'(NMax) : num_leds_q;

  always_comb begin
    for (int b = 0; b < ChanW; b++) begin
      peak_m[b] = (b < PW) ? peak_q[b] : 1'b0;
    end
  end

  rcw_bounds u_bounds (
    .clk_i    (clk_i),
    .n_i      (n_sat),
    .bounds_o (bounds)
  );

  // Pipeline links: index 0 from the front stages, PW into the output stage
  logic [PW:0] lnk_valid;
  logic [PW:0] lnk_ready;
  div_t        lnk_data [PW+1];

  rcw_locate u_locate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .pos_i    (position_i),
    .n_i      (n_sat),
    .bounds_i (bounds),
    .peak_i   (peak_m),
    .valid_o  (lnk_valid[0]),
    .ready_i  (lnk_ready[0]),
    .data_o   (lnk_data[0])
  );

  // One divider stage per ramp bit, most significant first
  for (genvar i = 0; i < PW; i++) begin : g_div
    rcw_div_stage #(
      .BIT (PW - 1 - i)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lnk_valid[i]),
      .ready_o (lnk_ready[i]),
      .data_i  (lnk_data[i]),
      .valid_o (lnk_valid[i+1]),
      .ready_i (lnk_ready[i+1]),
      .data_o  (lnk_data[i+1])
    );
  end

  rcw_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lnk_valid[PW]),
    .ready_o (lnk_ready[PW]),
    .data_i  (lnk_data[PW]),
    .peak_i  (peak_m),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o),
    .oor_o   (out_of_range_o)
  );

  // Out-of-range beats are black
  a_oor_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> red_o == '0 && green_o == '0 && blue_o == '0)
    else $error("out-of-range beat is not black");

  // In range, one channel always sits at peak
  a_one_at_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |->
      (red_o == peak_m || green_o == peak_m || blue_o == peak_m))
    else $error("no channel at peak brightness");

  // No channel exceeds peak
  a_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_o <= peak_m && green_o <= peak_m && blue_o <= peak_m)
    else $error("channel above peak brightness");

endmodule
